### rtl/core/hti_pkg.sv
package hti_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int POINT_BITS  = 16;
  localparam int INDEX_BITS  = 6;
  localparam int CFG_BITS    = 7;
  localparam int WGT_W       = FRAC_BITS + 1;
  localparam int ACC_W       = HEIGHT_BITS + WGT_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int TDATA_W     = 64;

  localparam logic [WGT_W:0] ONE = (WGT_W + 1)'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_GRID_COLUMNS = 1'b0;
  localparam logic CFG_GRID_ROWS    = 1'b1;

  function automatic int entry_bits(input int aw);
    return 2 + 3 * aw + HEIGHT_BITS + 3 * WGT_W;
  endfunction

endpackage

### rtl/core/hti_queue.sv
module hti_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] q_data
);

  localparam int PW = $clog2(hti_pkg::QUEUE_DEPTH);

  logic [W-1:0]  slots [hti_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full    = count == (PW + 1)'(hti_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/hti_front.sv
module hti_front #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int AW          = 12
) (
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic                                     command,
  input  logic [hti_pkg::INDEX_BITS-1:0]           write_column,
  input  logic [hti_pkg::INDEX_BITS-1:0]           write_row,
  input  logic signed [hti_pkg::HEIGHT_BITS-1:0]   height_value,
  input  logic signed [hti_pkg::POINT_BITS-1:0]    point_x,
  input  logic signed [hti_pkg::POINT_BITS-1:0]    point_y,
  input  logic [hti_pkg::CFG_BITS-1:0]             grid_columns,
  input  logic [hti_pkg::CFG_BITS-1:0]             grid_rows,
  input  logic                                     full,
  output logic                                     push,
  output logic [hti_pkg::entry_bits(AW)-1:0]       push_data
);

  localparam int CB = hti_pkg::CFG_BITS;
  localparam int WW = hti_pkg::WGT_W;
  localparam int FB = hti_pkg::FRAC_BITS;
  localparam int CFG_MAX = (1 << CB) - 1;
  localparam logic [CB-1:0] EXT_X = CB'(MAX_COLUMNS > CFG_MAX ? CFG_MAX : MAX_COLUMNS);
  localparam logic [CB-1:0] EXT_Y = CB'(MAX_ROWS > CFG_MAX ? CFG_MAX : MAX_ROWS);

  typedef struct packed {
    logic                                   query;
    logic                                   wr_en;
    logic [AW-1:0]                          addr0;
    logic [AW-1:0]                          addr1;
    logic [AW-1:0]                          addr2;
    logic signed [hti_pkg::HEIGHT_BITS-1:0] wr_data;
    logic [WW-1:0]                          w0;
    logic [WW-1:0]                          w1;
    logic [WW-1:0]                          w2;
  } entry_t;

  function automatic logic [CB-1:0] extent_m1(input logic [CB-1:0] r,
                                              input logic [CB-1:0] lim);
    logic [CB-1:0] e;
    e = r;
    if (r == '0) begin
      e = CB'(1);
    end else if (r > lim) begin
      e = lim;
    end
    return e - 1'b1;
  endfunction

  // truncate toward zero: floor plus one for negative values with a fraction
  function automatic logic signed [FB:0] trunc_idx(input logic signed [15:0] p);
    return $signed({p[15], p[15:8]}) + $signed({{FB{1'b0}}, p[15] && (p[7:0] != '0)});
  endfunction

  function automatic logic [CB-1:0] clamp_idx(input logic signed [FB:0] v,
                                              input logic [CB-1:0] lim);
    logic [CB-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v[FB-1:0] > FB'(lim)) begin
      c = lim;
    end else begin
      c = v[CB-1:0];
    end
    return c;
  endfunction

  function automatic logic [WW-1:0] frac_off(input logic signed [15:0] p,
                                             input logic [CB-1:0] idx);
    logic signed [17:0] d;
    logic [WW-1:0]      f;
    d = 18'(p) - $signed(18'({idx, {FB{1'b0}}}));
    if (d < 0) begin
      f = '0;
    end else if (d > $signed(18'(hti_pkg::ONE))) begin
      f = WW'(hti_pkg::ONE);
    end else begin
      f = d[WW-1:0];
    end
    return f;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CB-1:0] col,
                                              input logic [CB-1:0] row);
    return AW'(AW'(row) * AW'(MAX_COLUMNS)) + AW'(col);
  endfunction

  logic [CB-1:0]         wm1;
  logic [CB-1:0]         hm1;
  logic signed [FB:0]    xi;
  logic signed [FB:0]    yi;
  logic [CB-1:0]         x0;
  logic [CB-1:0]         x1;
  logic [CB-1:0]         y0;
  logic [CB-1:0]         y1;
  logic [WW-1:0]         dx;
  logic [WW-1:0]         dy;
  logic [WW:0]           dsum;
  logic                  upper;
  entry_t                e;

  assign s_tready  = !full;
  assign push      = s_tvalid && !full;
  assign push_data = e;

  always_comb begin
    wm1   = extent_m1(grid_columns, EXT_X);
    hm1   = extent_m1(grid_rows, EXT_Y);
    xi    = trunc_idx(point_x);
    yi    = trunc_idx(point_y);
    x0    = clamp_idx(xi, wm1);
    y0    = clamp_idx(yi, hm1);
    x1    = clamp_idx(xi + $signed((FB + 1)'(1)), wm1);
    y1    = clamp_idx(yi + $signed((FB + 1)'(1)), hm1);
    dx    = frac_off(point_x, x0);
    dy    = frac_off(point_y, y0);
    dsum  = (WW + 1)'(dx) + (WW + 1)'(dy);
    upper = dsum > hti_pkg::ONE;

    e         = '0;
    e.query   = command == hti_pkg::CMD_QUERY;
    e.wr_data = height_value;
    if (command == hti_pkg::CMD_WRITE) begin
      e.wr_en = (int'(write_column) < MAX_COLUMNS) && (int'(write_row) < MAX_ROWS);
      e.addr0 = AW'(AW'(write_row) * AW'(MAX_COLUMNS)) + AW'(write_column);
    end else if (upper) begin
      e.addr0 = cell_addr(x1, y1);
      e.w0    = WW'(dsum - hti_pkg::ONE);
      e.addr1 = cell_addr(x1, y0);
      e.w1    = WW'(hti_pkg::ONE - (WW + 1)'(dy));
      e.addr2 = cell_addr(x0, y1);
      e.w2    = WW'(hti_pkg::ONE - (WW + 1)'(dx));
    end else begin
      e.addr0 = cell_addr(x0, y0);
      e.w0    = WW'(hti_pkg::ONE - dsum);
      e.addr1 = cell_addr(x1, y0);
      e.w1    = dx;
      e.addr2 = cell_addr(x0, y1);
      e.w2    = dy;
    end
  end

endmodule

### rtl/core/hti_back.sv
module hti_back #(
  parameter int AW = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  input  logic [hti_pkg::entry_bits(AW)-1:0]     q_data,
  output logic                                   pop,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [hti_pkg::HEIGHT_BITS-1:0]        m_tdata
);

  localparam int HB = hti_pkg::HEIGHT_BITS;
  localparam int WW = hti_pkg::WGT_W;
  localparam int AC = hti_pkg::ACC_W;
  localparam int FB = hti_pkg::FRAC_BITS;
  localparam int RW = AC - FB;

  typedef struct packed {
    logic                   query;
    logic                   wr_en;
    logic [AW-1:0]          addr0;
    logic [AW-1:0]          addr1;
    logic [AW-1:0]          addr2;
    logic signed [HB-1:0]   wr_data;
    logic [WW-1:0]          w0;
    logic [WW-1:0]          w1;
    logic [WW-1:0]          w2;
  } entry_t;

  entry_t               e;
  logic                 adv;
  logic [1:0]           cnt;
  logic [AW-1:0]        raddr;
  logic [WW-1:0]        rweight;
  logic                 issue;

  logic signed [HB-1:0] grid [1 << AW];
  logic signed [HB-1:0] rdata;

  logic                 r_valid;
  logic                 r_first;
  logic                 r_last;
  logic [WW-1:0]        r_weight;
  logic                 p_valid;
  logic                 p_first;
  logic                 p_last;
  logic signed [AC-1:0] p_prod;
  logic                 a_done;
  logic signed [AC-1:0] acc;
  logic signed [AC-1:0] rnd;
  logic signed [RW-1:0] shifted;
  logic [HB-1:0]        sat;

  assign e     = q_data;
  // the whole back end freezes while a finished result waits
  assign adv   = !m_tvalid || m_tready;
  assign issue = adv && q_valid;
  assign pop   = issue && (!e.query || cnt == 2'd2);

  always_comb begin
    case (cnt)
      2'd0:    begin raddr = e.addr0; rweight = e.w0; end
      2'd1:    begin raddr = e.addr1; rweight = e.w1; end
      2'd2:    begin raddr = e.addr2; rweight = e.w2; end
      default: begin raddr = e.addr0; rweight = e.w0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue && !e.query && e.wr_en) begin
      grid[e.addr0] <= e.wr_data;
    end
    if (adv) begin
      rdata <= grid[raddr];
    end
  end

  always_comb begin
    rnd     = acc + AC'(hti_pkg::HALF);
    shifted = rnd[AC-1:FB];
    if (shifted[RW-1:HB-1] == '0 || shifted[RW-1:HB-1] == '1) begin
      sat = shifted[HB-1:0];
    end else begin
      sat = {shifted[RW-1], {(HB - 1){!shifted[RW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_first  <= cnt == 2'd0;
      r_last   <= cnt == 2'd2;
      r_weight <= rweight;
      p_first  <= r_first;
      p_last   <= r_last;
      p_prod   <= $signed(AC'(rdata)) * $signed(AC'({1'b0, r_weight}));
      if (p_valid) begin
        acc <= p_first ? p_prod : acc + p_prod;
      end
      if (a_done) begin
        m_tdata <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      r_valid  <= 1'b0;
      p_valid  <= 1'b0;
      a_done   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      if (issue && e.query) begin
        cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
      end
      r_valid  <= issue && e.query;
      p_valid  <= r_valid;
      a_done   <= p_valid && p_last;
      m_tvalid <= a_done;
    end
  end

endmodule

### rtl/core/heightmap_triangle_interpolator.sv
// Heightmap triangle interpolator.
// Input stream (s_*): every transaction is a command. tuser = 0 writes
// height_value into grid entry (write_column, write_row); tuser = 1 queries
// the grid at (point_x, point_y), signed Q7.8 grid units. A write gives no
// output; a query gives one height_result on the output stream (m_*).
// Config port: cfg_write with cfg_index 0 sets grid_columns, 1 sets grid_rows;
// write only while no query is in flight.
// A query result passes through the grid read, product, accumulator and
// output registers on its way from the command queue to m_tdata.
// Throughput: a query reads the grid memory once per triangle corner, one
// corner after another, while a write leaves the back end as soon as it is
// taken; the input side takes a transaction every cycle while the 4-entry
// command queue has room.
// Reset clears the queue and the pipeline and sets both grid extents to 1.
// Grid contents are not cleared: read only entries that were written.
// When the receiver holds m_tready low, the result stays on m_tdata, the
// back end halts, and input keeps being taken until the queue fills.
module heightmap_triangle_interpolator #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // write_column[5:0], write_row[11:6], height_value[27:12],
  // point_x[43:28], point_y[59:44], zero fill[63:60]
  input  logic [hti_pkg::TDATA_W-1:0]         s_tdata,
  // command[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // height_result[15:0]
  output logic [hti_pkg::HEIGHT_BITS-1:0]     m_tdata,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [hti_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int AW = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int EW = hti_pkg::entry_bits(AW);

  logic [hti_pkg::CFG_BITS-1:0] grid_columns;
  logic [hti_pkg::CFG_BITS-1:0] grid_rows;
  logic                         push;
  logic [EW-1:0]                push_data;
  logic                         full;
  logic                         pop;
  logic                         q_valid;
  logic [EW-1:0]                q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= hti_pkg::CFG_BITS'(1);
      grid_rows    <= hti_pkg::CFG_BITS'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        hti_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data;
        hti_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data;
        default:                   grid_rows    <= grid_rows;
      endcase
    end
  end

  hti_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .AW          (AW)
  ) u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .command      (s_tuser),
    .write_column (s_tdata[5:0]),
    .write_row    (s_tdata[11:6]),
    .height_value (s_tdata[27:12]),
    .point_x      (s_tdata[43:28]),
    .point_y      (s_tdata[59:44]),
    .grid_columns (grid_columns),
    .grid_rows    (grid_rows),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  hti_queue #(
    .W (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  hti_back #(
    .AW (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### tb/sv/heightmap_triangle_interpolator_checker.sv
module heightmap_triangle_interpolator_checker #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // write_column, write_row, height_value, point_x, point_y, zero fill
  input  logic [hti_pkg::TDATA_W-1:0]       s_tdata,
  // command
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // height_result
  input  logic [hti_pkg::HEIGHT_BITS-1:0]   m_tdata,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [hti_pkg::CFG_BITS-1:0]      cfg_data,
  output int                                mismatches,
  output int                                heights_pending,
  output int                                heights_checked
);
  import hti_pkg::*;

  localparam int COL_LSB    = 0;
  localparam int ROW_LSB    = COL_LSB + INDEX_BITS;
  localparam int HEIGHT_LSB = ROW_LSB + INDEX_BITS;
  localparam int PX_LSB     = HEIGHT_LSB + HEIGHT_BITS;
  localparam int PY_LSB     = PX_LSB + POINT_BITS;
  localparam int CELL       = 2 ** FRAC_BITS;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic signed [HEIGHT_BITS-1:0] height;
    logic signed [POINT_BITS-1:0]  px;
    logic signed [POINT_BITS-1:0]  py;
  } height_due_t;

  height_due_t                   heights_due [$];
  logic signed [HEIGHT_BITS-1:0] grid_heights [MAX_COLUMNS*MAX_ROWS];
  logic [CFG_BITS-1:0]           columns_reg = 1;
  logic [CFG_BITS-1:0]           rows_reg = 1;
  int                            errs;
  int                            checked;

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // A zero setting acts as one, anything past the array acts as the array size.
  function automatic int extent_of(input logic [CFG_BITS-1:0] setting, input int most);
    return clip(int'(setting), 1, most);
  endfunction

  function automatic logic signed [HEIGHT_BITS-1:0] interpolate_height(
    input logic signed [POINT_BITS-1:0] px,
    input logic signed [POINT_BITS-1:0] py
  );
    int     wc, hr, x, y, x0, y0, x1, y1, dx, dy;
    longint z00, z10, z01, z11, acc, r, hi, lo;
    wc = extent_of(columns_reg, MAX_COLUMNS);
    hr = extent_of(rows_reg, MAX_ROWS);
    x  = px;
    y  = py;
    // truncate toward zero, then pin both corners inside the grid
    x0 = x / CELL;
    y0 = y / CELL;
    x1 = clip(x0 + 1, 0, wc - 1);
    y1 = clip(y0 + 1, 0, hr - 1);
    x0 = clip(x0, 0, wc - 1);
    y0 = clip(y0, 0, hr - 1);
    z00 = grid_heights[y0*MAX_COLUMNS + x0];
    z10 = grid_heights[y0*MAX_COLUMNS + x1];
    z01 = grid_heights[y1*MAX_COLUMNS + x0];
    z11 = grid_heights[y1*MAX_COLUMNS + x1];
    dx = clip(x - x0*CELL, 0, CELL);
    dy = clip(y - y0*CELL, 0, CELL);
    if (dx + dy <= CELL) begin
      acc = z00*(CELL - dx - dy) + z10*dx + z01*dy;
    end else begin
      acc = z10*(CELL - dy) + z01*(CELL - dx) + z11*(dx + dy - CELL);
    end
    r  = (acc + CELL/2) >>> FRAC_BITS;
    hi = (longint'(1) << (HEIGHT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return HEIGHT_BITS'(r);
  endfunction

  always @(posedge clk) begin
    height_due_t                   due;
    logic [INDEX_BITS-1:0]         col;
    logic [INDEX_BITS-1:0]         row;
    logic signed [HEIGHT_BITS-1:0] got;
    if (rst) begin
      heights_due.delete();
      columns_reg = 1;
      rows_reg    = 1;
      errs        = 0;
      checked     = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_GRID_COLUMNS) begin
          columns_reg = cfg_data;
        end else begin
          rows_reg = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_WRITE) begin
          col = s_tdata[COL_LSB +: INDEX_BITS];
          row = s_tdata[ROW_LSB +: INDEX_BITS];
          if (col < MAX_COLUMNS && row < MAX_ROWS) begin
            grid_heights[row*MAX_COLUMNS + col] = s_tdata[HEIGHT_LSB +: HEIGHT_BITS];
          end
        end else begin
          due.px     = s_tdata[PX_LSB +: POINT_BITS];
          due.py     = s_tdata[PY_LSB +: POINT_BITS];
          due.height = interpolate_height(due.px, due.py);
          heights_due.push_back(due);
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (heights_due.size() == 0) begin
          if (errs < REPORT_MAX) $display("unexpected height %0d with no query pending", got);
          errs++;
        end else begin
          due = heights_due.pop_front();
          checked++;
          if (got !== due.height) begin
            if (errs < REPORT_MAX) begin
              $display("height mismatch at x=%0d y=%0d: expected %0d, got %0d",
                       due.px, due.py, due.height, got);
            end
            errs++;
          end
        end
      end
    end
    mismatches      <= errs;
    heights_pending <= heights_due.size();
    heights_checked <= checked;
  end

endmodule

### tb/sv/heightmap_triangle_interpolator_tb.sv
module heightmap_triangle_interpolator_tb;
  import hti_pkg::*;

  localparam int COLS        = 64;
  localparam int ROWS        = 64;
  localparam int CELL        = 2 ** FRAC_BITS;
  localparam int IDLE_PCT    = 23;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 80;
  localparam int PHASES      = 9;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [TDATA_W-1:0]     s_tdata   = '0;
  logic                   s_tuser   = CMD_WRITE;
  logic                   m_tready  = 1'b0;
  logic                   cfg_write = 1'b0;
  logic                   cfg_index = CFG_GRID_COLUMNS;
  logic [CFG_BITS-1:0]    cfg_data  = '0;
  wire                    s_tready;
  wire                    m_tvalid;
  wire [HEIGHT_BITS-1:0]  m_tdata;

  int                     mismatches;
  int                     heights_pending;
  int                     heights_checked;
  bit                     no_gaps;
  int                     items;
  int                     writes;
  int                     queries;
  int                     settings;
  int                     stall_cycles;
  int                     cur_cols = 1;
  int                     cur_rows = 1;
  bit                     written [COLS*ROWS];

  heightmap_triangle_interpolator #(
    .MAX_COLUMNS(COLS),
    .MAX_ROWS   (ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  heightmap_triangle_interpolator_checker #(
    .MAX_COLUMNS(COLS),
    .MAX_ROWS   (ROWS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .heights_pending(heights_pending),
    .heights_checked(heights_checked)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [TDATA_W-1:0] pack(
    input logic [INDEX_BITS-1:0]  col,
    input logic [INDEX_BITS-1:0]  row,
    input logic [HEIGHT_BITS-1:0] height,
    input logic [POINT_BITS-1:0]  px,
    input logic [POINT_BITS-1:0]  py
  );
    return {{(TDATA_W - 2*INDEX_BITS - HEIGHT_BITS - 2*POINT_BITS){1'b0}},
            py, px, height, row, col};
  endfunction

  task automatic push(input logic cmd, input logic [TDATA_W-1:0] data);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items++;
  endtask

  task automatic put_height(input int col, input int row, input logic [HEIGHT_BITS-1:0] h);
    written[row*COLS + col] = 1'b1;
    writes++;
    push(CMD_WRITE, pack(INDEX_BITS'(col), INDEX_BITS'(row), h,
                         16'($urandom), 16'($urandom)));
  endtask

  task automatic fill_corner(input int col, input int row);
    if (!written[row*COLS + col]) put_height(col, row, 16'($urandom));
  endtask

  // Load any corner the query will read that has never been loaded, then query.
  task automatic probe(input logic signed [POINT_BITS-1:0] px,
                       input logic signed [POINT_BITS-1:0] py);
    int wc, hr, x0, y0, x1, y1;
    wc = clip(cur_cols, 1, COLS);
    hr = clip(cur_rows, 1, ROWS);
    x0 = int'(px) / CELL;
    y0 = int'(py) / CELL;
    x1 = clip(x0 + 1, 0, wc - 1);
    y1 = clip(y0 + 1, 0, hr - 1);
    x0 = clip(x0, 0, wc - 1);
    y0 = clip(y0, 0, hr - 1);
    fill_corner(x0, y0);
    fill_corner(x1, y0);
    fill_corner(x0, y1);
    fill_corner(x1, y1);
    queries++;
    push(CMD_QUERY, pack(6'($urandom), 6'($urandom), 16'($urandom), px, py));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (heights_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input int cols, input int rows);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= CFG_GRID_COLUMNS;
    cfg_data  <= CFG_BITS'(cols);
    @(posedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= CFG_BITS'(rows);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
    settings++;
  endtask

  initial begin
    int                           phase_cols [PHASES];
    int                           phase_rows [PHASES];
    int                           target;
    int                           wc;
    int                           hr;
    int                           sel;
    int                           fx;
    logic signed [POINT_BITS-1:0] px;
    logic signed [POINT_BITS-1:0] py;

    phase_cols = '{8, 64, 0, 127, 1, 64, 2, 0, 0};
    phase_rows = '{6, 64, 0, 65, 64, 1, 2, 0, 0};
    phase_cols[7] = $urandom_range(1, COLS);
    phase_rows[7] = $urandom_range(1, ROWS);
    phase_cols[8] = $urandom_range(1, COLS);
    phase_rows[8] = $urandom_range(1, ROWS);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-cell grid out of reset: every point collapses onto entry (0,0)
    put_height(0, 0, 16'sd32767);
    probe(16'sd0, 16'sd0);
    probe(-16'sd32768, -16'sd32768);
    probe(16'sd32767, 16'sd32767);
    put_height(0, 0, -16'sd32768);
    probe(16'sd128, 16'sd77);

    // full grid: extreme heights around the far cell, both triangles and the diagonal
    set_grid(COLS, ROWS);
    put_height(63, 63, -16'sd32768);
    put_height(62, 63, 16'sd32767);
    put_height(63, 62, 16'sd32767);
    put_height(62, 62, -16'sd32768);
    probe(16'(63*CELL + 255), 16'(63*CELL + 255));
    probe(16'(62*CELL + 128), 16'(62*CELL + 128));
    probe(16'(62*CELL + 200), 16'(62*CELL + 100));
    probe(16'(62*CELL + 10), 16'(62*CELL + 20));
    probe(16'sd32767, -16'sd1);
    probe(-16'sd257, 16'sd5);
    probe(-16'sd32768, 16'sd32767);

    for (int p = 0; p < PHASES; p++) begin
      set_grid(phase_cols[p], phase_rows[p]);
      no_gaps = (p == 1);
      wc = clip(cur_cols, 1, COLS);
      hr = clip(cur_rows, 1, ROWS);
      target = items + PHASE_ITEMS;
      while (items < target) begin
        sel = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 20) begin
          put_height($urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1), 16'($urandom));
        end else begin
          if (sel < 7) begin
            // mostly inside the grid, with a half cell of overhang on each side
            px = 16'(int'($urandom_range(0, wc*CELL + 255)) - 128);
            py = 16'(int'($urandom_range(0, hr*CELL + 255)) - 128);
          end else if (sel == 7) begin
            // exactly on a cell diagonal
            fx = $urandom_range(1, CELL - 1);
            px = 16'(int'($urandom_range(0, wc - 1))*CELL + fx);
            py = 16'(int'($urandom_range(0, hr - 1))*CELL + CELL - fx);
          end else begin
            px = 16'($urandom);
            py = 16'($urandom);
          end
          probe(px, py);
        end
      end
    end
    no_gaps = 1'b0;

    drain();
    $display("run covered %0d writes and %0d queries over %0d grid settings",
             writes, queries, settings);
    $display("%0d heights compared, %0d mismatches", heights_checked, mismatches);
    if (mismatches == 0 && heights_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
